>>> rtl/core/hamming_stream_encoder_assert.svh
// Assertion macros for the Hamming stream encoder.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef HAMMING_STREAM_ENCODER_ASSERT_SVH
`define HAMMING_STREAM_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
`define HSE_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("hamming_stream_encoder: same-cycle check failed");
`define HSE_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("hamming_stream_encoder: next-cycle check failed");
`else
`define HSE_ASSERT_IMP(lbl, a, c)
`define HSE_ASSERT_NXT(lbl, a, c)
`endif
`endif

>>> rtl/core/hse_pkg.sv
package hse_pkg;

	localparam int BYTE_W = 8;
	localparam int CFG_W = 3;
	localparam int LEFT_W = 4;

	localparam logic [CFG_W-1:0] CFG_RESET = 3'd3;
	localparam logic [CFG_W-1:0] MIN_PARITY = 3'd2;
	localparam logic [2:0] PACK_LAST = 3'(BYTE_W - 1);

	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic load_bit;
		logic pop;
	} col_ctl_t;

	typedef struct packed {
		logic last_data;
		logic data_bit;
	} col_sts_t;

	typedef struct packed {
		logic clear;
		logic push;
		logic push_bit;
		logic mark_last;
	} pak_ctl_t;

	typedef struct packed {
		logic can_push;
		logic byte_end;
	} pak_sts_t;

endpackage

>>> rtl/core/hse_collect.sv
module hse_collect #(
	parameter int MAX_PARITY_BITS = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hse_pkg::col_ctl_t             ctl,
	input  logic [hse_pkg::CFG_W-1:0]     r,
	output hse_pkg::col_sts_t             sts,
	output logic [MAX_PARITY_BITS-1:0]    syn
);
	import hse_pkg::*;

	localparam int PW = MAX_PARITY_BITS;
	localparam int KMAX = 2 ** PW - 1 - PW;
	localparam int DW = $clog2(KMAX + 1);
	localparam int IW = (KMAX > 1) ? $clog2(KMAX) : 1;

	logic [KMAX-1:0] dat_q;
	logic [DW-1:0]   dcnt_q;
	logic [PW-1:0]   pos_q;
	logic [PW-1:0]   syn_q;
	logic [PW-1:0]   pos_inc;
	logic [PW-1:0]   pos_nxt;
	logic [PW:0]     nval;
	logic [PW:0]     kval;
	logic [PW:0]     klast;
	logic [IW-1:0]   kidx;

	always_comb begin
		nval = ((PW + 1)'(1) << r) - (PW + 1)'(1);
		kval = nval - (PW + 1)'(r);
		klast = kval - (PW + 1)'(1);
		kidx = klast[IW-1:0];
		pos_inc = pos_q + PW'(1);
		pos_nxt = ((pos_inc & (pos_inc - PW'(1))) == '0) ? pos_inc + PW'(1) : pos_inc;
	end

	assign sts.last_data = (dcnt_q == klast[DW-1:0]);
	assign sts.data_bit = dat_q[kidx];
	assign syn = syn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
			pos_q <= PW'(3);
			syn_q <= '0;
		end else if (ctl.clear) begin
			dcnt_q <= '0;
			pos_q <= PW'(3);
			syn_q <= '0;
		end else if (ctl.load) begin
			dcnt_q <= dcnt_q + DW'(1);
			pos_q <= pos_nxt;
			if (ctl.load_bit) begin
				syn_q <= syn_q ^ pos_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			dat_q <= (dat_q << 1) | KMAX'(ctl.load_bit);
		end else if (ctl.pop) begin
			dat_q <= dat_q << 1;
		end
	end

endmodule

>>> rtl/core/hse_pack.sv
module hse_pack (
	input  logic              clk,
	input  logic              arst_n,
	input  hse_pkg::pak_ctl_t ctl,
	input  logic              out_stall,
	output hse_pkg::pak_sts_t sts,
	output logic              out_valid,
	output hse_pkg::byte_t    code_byte,
	output logic              last_out
);
	import hse_pkg::*;

	logic [BYTE_W-2:0] pk_q;
	logic [2:0]        cnt_q;
	logic              valid_q;
	byte_t             byte_q;
	logic              last_q;
	logic              take;

	assign take = valid_q && !out_stall;
	assign sts.byte_end = (cnt_q == PACK_LAST);
	assign sts.can_push = !(sts.byte_end && valid_q && out_stall);
	assign out_valid = valid_q;
	assign code_byte = byte_q;
	assign last_out = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			cnt_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_q <= 1'b0;
			end
			if (ctl.push) begin
				if (sts.byte_end) begin
					valid_q <= 1'b1;
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			pk_q <= {pk_q[BYTE_W-3:0], ctl.push_bit};
			if (sts.byte_end) begin
				byte_q <= {pk_q, ctl.push_bit};
				last_q <= ctl.mark_last;
			end
		end
	end

endmodule

>>> rtl/core/hamming_stream_encoder.sv
// Hamming stream encoder.
// The input channel (in_valid, in_stall, data_byte, last_in) takes one file word at a time.
// The output channel (out_valid, out_stall, code_byte, last_out) gives the encoded words.
// The configuration channel (cfg_valid, cfg_ready, control_bits) sets the parity count r,
// which is clamped to the range two to MAX_PARITY_BITS; a write clears any partial stream.
// The bits of each input word are shifted one per cycle into the codeword data register
// while the syndrome is built, pausing whenever a completed codeword is being sent.
// Each completed codeword of n = 2^r - 1 bits is then sent one bit per cycle into the byte
// packer while the packer can take a bit. The last word of a stream pads its final
// codeword with zero data bits and fills the packer with zero bits up to a byte boundary;
// its final output word carries last_out. A new input word is accepted only when idle,
// after the last word and all codewords that it completed have gone into the packer.
// Each output word is offered in the cycle after the edge that packs its eighth bit.
// One output word waits in the output register while encoding continues; when the receiver
// stalls, the packer halts on the bit that would complete the next word.
// After reset r is three, the output is empty and the block waits for a new stream.
`include "hamming_stream_encoder_assert.svh"

module hamming_stream_encoder #(
	parameter int MAX_PARITY_BITS = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [hse_pkg::CFG_W-1:0] control_bits,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  hse_pkg::byte_t            data_byte,
	input  logic                      last_in,
	output logic                      out_valid,
	input  logic                      out_stall,
	output hse_pkg::byte_t            code_byte,
	output logic                      last_out
);
	import hse_pkg::*;

	localparam int PW = MAX_PARITY_BITS;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FILL = 3'd1;
	localparam logic [2:0] S_PAD = 3'd2;
	localparam logic [2:0] S_EMIT = 3'd3;
	localparam logic [2:0] S_FLUSH = 3'd4;

	logic [2:0]        state_q;
	logic [CFG_W-1:0]  cfg_q;
	byte_t             in_sr_q;
	logic [LEFT_W-1:0] left_q;
	logic              last_q;
	logic              fin_q;
	logic [PW-1:0]     ep_q;

	logic [CFG_W-1:0]  rc;
	logic [PW:0]       nfull;
	logic [PW-1:0]     nval;
	logic [PW-1:0]     syn;
	logic              ep_pow2;
	logic              ep_end;
	logic              emit_bit;
	logic              cfg_wr;
	logic              step;
	col_ctl_t          cctl;
	col_sts_t          csts;
	pak_ctl_t          pctl;
	pak_sts_t          psts;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		if (cfg_q < MIN_PARITY) begin
			rc = MIN_PARITY;
		end else if (cfg_q > CFG_W'(PW)) begin
			rc = CFG_W'(PW);
		end else begin
			rc = cfg_q;
		end
		nfull = ((PW + 1)'(1) << rc) - (PW + 1)'(1);
		nval = nfull[PW-1:0];
		ep_pow2 = ((ep_q & (ep_q - PW'(1))) == '0);
		ep_end = (ep_q == nval);
		emit_bit = ep_pow2 ? |(syn & ep_q) : csts.data_bit;
		step = psts.can_push && !cfg_wr;
	end

	always_comb begin
		cctl.clear = cfg_wr || (state_q == S_EMIT && psts.can_push && ep_end);
		cctl.load = (state_q == S_FILL || state_q == S_PAD) && !cfg_wr;
		cctl.load_bit = (state_q == S_FILL) && in_sr_q[BYTE_W-1];
		cctl.pop = (state_q == S_EMIT) && step && !ep_pow2;
		pctl.clear = cfg_wr;
		pctl.push = (state_q == S_EMIT || state_q == S_FLUSH) && step;
		pctl.push_bit = (state_q == S_EMIT) && emit_bit;
		pctl.mark_last = (state_q == S_EMIT && ep_end && fin_q) || (state_q == S_FLUSH);
	end

	hse_collect #(
		.MAX_PARITY_BITS(PW)
	) u_collect (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (cctl),
		.r     (rc),
		.sts   (csts),
		.syn   (syn)
	);

	hse_pack u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (pctl),
		.out_stall(out_stall),
		.sts      (psts),
		.out_valid(out_valid),
		.code_byte(code_byte),
		.last_out (last_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cfg_q <= CFG_RESET;
			in_sr_q <= '0;
			left_q <= '0;
			last_q <= 1'b0;
			fin_q <= 1'b0;
			ep_q <= PW'(1);
		end else if (cfg_wr) begin
			state_q <= S_IDLE;
			cfg_q <= control_bits;
			left_q <= '0;
			last_q <= 1'b0;
			fin_q <= 1'b0;
			ep_q <= PW'(1);
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						in_sr_q <= data_byte;
						left_q <= LEFT_W'(BYTE_W);
						last_q <= last_in;
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					in_sr_q <= in_sr_q << 1;
					left_q <= left_q - LEFT_W'(1);
					if (csts.last_data) begin
						state_q <= S_EMIT;
						fin_q <= last_q && (left_q == LEFT_W'(1));
					end else if (left_q == LEFT_W'(1)) begin
						state_q <= last_q ? S_PAD : S_IDLE;
					end
				end
				S_PAD: begin
					if (csts.last_data) begin
						state_q <= S_EMIT;
						fin_q <= 1'b1;
					end
				end
				S_EMIT: begin
					if (psts.can_push) begin
						if (ep_end) begin
							ep_q <= PW'(1);
							if (fin_q) begin
								state_q <= psts.byte_end ? S_IDLE : S_FLUSH;
							end else begin
								state_q <= (left_q == '0) ? S_IDLE : S_FILL;
							end
						end else begin
							ep_q <= ep_q + PW'(1);
						end
					end
				end
				S_FLUSH: begin
					if (psts.can_push && psts.byte_end) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`HSE_ASSERT_IMP(a_no_overwrite, pctl.push && psts.byte_end, !(out_valid && out_stall))
	`HSE_ASSERT_IMP(a_flush_final, state_q == S_FLUSH, fin_q)
	`HSE_ASSERT_NXT(a_cfg_idle, cfg_valid, state_q == S_IDLE)
	`HSE_ASSERT_IMP(a_ep_range, state_q == S_EMIT, ep_q != '0 && ep_q <= nval)

endmodule

>>> tb/tb_hamming_stream_encoder.sv
module tb_hamming_stream_encoder;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PARITY = 6;
	localparam int SETTLE_CYCLES = 256;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		hse_pkg::byte_t data;
		logic last;
	} file_word_t;

	typedef struct packed {
		hse_pkg::byte_t code;
		logic last;
	} code_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [hse_pkg::CFG_W-1:0] control_bits = hse_pkg::CFG_RESET;
	logic in_valid = 1'b0;
	logic in_stall;
	hse_pkg::byte_t data_byte = '0;
	logic last_in = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	hse_pkg::byte_t code_byte;
	logic last_out;

	file_word_t file_q[$];
	code_word_t code_q[$];
	file_word_t next_word;
	code_word_t want;

	logic in_taken = 1'b0;
	int send_idle_pct = 15;
	int recv_idle_pct = 66;
	int words_queued = 0;
	int words_taken = 0;
	int cfg_writes = 0;
	int fail_count = 0;
	int quiet_cycles = 0;

	// Own copy of the encoder state.
	logic [hse_pkg::CFG_W-1:0] parity_cfg = hse_pkg::CFG_RESET;
	logic [63:0] held_data = '0;
	int unsigned held_fill = 0;
	hse_pkg::byte_t pack_reg = '0;
	int unsigned pack_fill = 0;

	hamming_stream_encoder #(
		.MAX_PARITY_BITS(MAX_PARITY)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.control_bits(control_bits),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.last_in(last_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.code_byte(code_byte),
		.last_out(last_out)
	);

	always #5 clk = ~clk;

	function automatic int unsigned parity_count(input logic [hse_pkg::CFG_W-1:0] v);
		int unsigned r;
		r = 32'(v);
		if (r < 32'(hse_pkg::MIN_PARITY)) r = 32'(hse_pkg::MIN_PARITY);
		if (r > MAX_PARITY) r = MAX_PARITY;
		return r;
	endfunction

	task automatic pack_code_bit(input logic b);
		pack_reg = {pack_reg[6:0], b};
		pack_fill++;
		if (pack_fill == 8) begin
			code_q.push_back('{code: pack_reg, last: 1'b0});
			pack_reg = '0;
			pack_fill = 0;
		end
	endtask

	task automatic emit_codeword(input logic [63:0] data, input int unsigned r);
		int unsigned n;
		int unsigned k;
		int unsigned di;
		logic [5:0] syn;
		logic [63:0] cw;
		n = (1 << r) - 1;
		k = n - r;
		di = 0;
		syn = '0;
		cw = '0;
		for (int p = 1; p <= n; p++) begin
			if ((p & (p - 1)) != 0) begin
				cw[p] = data[k - 1 - di];
				di++;
				if (cw[p]) syn = syn ^ 6'(p);
			end
		end
		for (int i = 0; i < r; i++) cw[1 << i] = syn[i];
		for (int p = 1; p <= n; p++) pack_code_bit(cw[p]);
	endtask

	task automatic absorb_file_word(input hse_pkg::byte_t d, input logic lst);
		int unsigned r;
		int unsigned k;
		int start_size;
		logic [63:0] kmask;
		code_word_t tail;
		r = parity_count(parity_cfg);
		k = (1 << r) - 1 - r;
		kmask = (64'd1 << k) - 64'd1;
		start_size = code_q.size();
		held_data = (held_data << 8) | 64'(d);
		held_fill += 8;
		while (held_fill >= k) begin
			emit_codeword((held_data >> (held_fill - k)) & kmask, r);
			held_fill -= k;
		end
		if (lst) begin
			if (held_fill > 0) begin
				held_data = held_data << (k - held_fill);
				emit_codeword(held_data & kmask, r);
			end
			while (pack_fill != 0) pack_code_bit(1'b0);
			if (code_q.size() > start_size) begin
				tail = code_q.pop_back();
				tail.last = 1'b1;
				code_q.push_back(tail);
			end
			held_fill = 0;
			pack_reg = '0;
			pack_fill = 0;
		end
		if (held_fill == 0) held_data = '0;
		else held_data = held_data & ((64'd1 << held_fill) - 64'd1);
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (file_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_word = file_q.pop_front();
					in_valid <= 1'b1;
					data_byte <= next_word.data;
					last_in <= next_word.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				if (code_q.size() == 0) begin
					fail_count++;
					$display("%0t: word with none expected, actual code_byte=%02h last_out=%0b",
						$time, code_byte, last_out);
				end else begin
					want = code_q.pop_front();
					if (code_byte !== want.code) begin
						fail_count++;
						$display("%0t: code_byte expected %02h actual %02h",
							$time, want.code, code_byte);
					end
					if (last_out !== want.last) begin
						fail_count++;
						$display("%0t: last_out expected %0b actual %0b",
							$time, want.last, last_out);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				parity_cfg = control_bits;
				held_data = '0;
				held_fill = 0;
				pack_reg = '0;
				pack_fill = 0;
				cfg_writes <= cfg_writes + 1;
			end
			if (in_valid && !in_stall) begin
				absorb_file_word(data_byte, last_in);
				words_taken <= words_taken + 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic add_word(input hse_pkg::byte_t d, input logic lst);
		file_q.push_back('{data: d, last: lst});
		words_queued++;
	endtask

	task automatic random_traffic(input int target);
		int made;
		int len;
		int kind;
		made = 0;
		while (made < target) begin
			kind = $urandom_range(7);
			len = $urandom_range(1, 10);
			for (int i = 0; i < len; i++) begin
				if (kind == 0)
					add_word(8'($urandom), 1'($urandom_range(1)));
				else
					add_word(8'($urandom_range(255)), (i == len - 1) && (kind != 1));
			end
			made += len;
		end
	endtask

	task automatic drain_and_settle();
		while (words_taken != words_queued || code_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_parity_cfg(input logic [hse_pkg::CFG_W-1:0] v);
		int seen;
		seen = cfg_writes;
		@(negedge clk);
		cfg_valid <= 1'b1;
		control_bits <= v;
		do @(negedge clk); while (cfg_writes == seen);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [hse_pkg::CFG_W-1:0] v, input int target);
		write_parity_cfg(v);
		random_traffic(target);
		drain_and_settle();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_word(8'h00, 1'b0);
		add_word(8'hFF, 1'b0);
		add_word(8'h80, 1'b0);
		add_word(8'h01, 1'b1);
		add_word(8'hFF, 1'b1);
		add_word(8'h00, 1'b1);
		add_word(8'h55, 1'b0);
		add_word(8'hAA, 1'b1);
		random_traffic(24);
		drain_and_settle();

		// Above the limit, so r is clamped to six; eight words fill one codeword and a padded second one.
		write_parity_cfg(3'd7);
		for (int i = 0; i < 7; i++) add_word(8'hFF, 1'b0);
		add_word(8'hFF, 1'b1);
		random_traffic(24);
		// Leave a partial stream behind so that the next write has to drop it.
		add_word(8'hC3, 1'b0);
		add_word(8'h3C, 1'b0);
		add_word(8'h81, 1'b0);
		drain_and_settle();

		run_phase(3'd0, 34);
		send_idle_pct = 66;
		recv_idle_pct = 15;
		run_phase(3'd6, 34);
		run_phase(3'd1, 34);
		run_phase(3'd4, 34);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(3'd2, 34);
		run_phase(3'd5, 34);
		run_phase(3'd3, 34);

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
